// File: rtl/sine_pwm_duty_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// sine pwm duty generator assertion macros
// shared concurrent check forms for the duty generator
// ----------------------------------------------------------------------------
`ifndef SINE_PWM_DUTY_GENERATOR_UNIT_DEFINES_SVH
`define SINE_PWM_DUTY_GENERATOR_UNIT_DEFINES_SVH

// implication in the same cycle
`define SPDG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication in the following cycle
`define SPDG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/spdg_pkg.sv
// ----------------------------------------------------------------------------
// spdg_pkg
// constants, control word types and microcode program of the duty generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spdg_pkg;

   // angle constants, q3.12 radians
   localparam logic [14:0] TWO_PI_Q12        = 15'd25736;
   localparam logic [14:0] THREE_HALF_PI_Q12 = 15'd19302;
   localparam logic [14:0] HALF_PI_Q12       = 15'd6434;
   localparam logic [14:0] PI_Q12            = 15'd12868;
   localparam logic [14:0] STEP_RESET        = 15'd306;

   // multiplier constants: reciprocals of 6 and 120, and the duty scale
   localparam logic [18:0] RECIP_6    = 19'd87382;   // ceil(2^19 / 6)
   localparam logic [18:0] RECIP_120  = 19'd279621;  // ceil(2^25 / 120)
   localparam logic [18:0] DUTY_SCALE = 19'd63;
   localparam logic [17:0] ONE_Q14    = 18'd16384;
   localparam int          DUTY_FULL  = 32;

   localparam int STEP_BITS = 3;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_OUT
   } cond_type;

   typedef enum logic [2:0] {
      A_M,
      A_X2,
      A_X3,
      A_X3R,
      A_X5R,
      A_BIAS
   } asel_type;

   typedef enum logic [2:0] {
      B_M,
      B_X2,
      B_RECIP6,
      B_RECIP120,
      B_SCALE
   } bsel_type;

   typedef enum logic [1:0] {
      POST_Q14,
      POST_SH19,
      POST_SH25,
      POST_Q16
   } post_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_X2,
      DST_X3,
      DST_X5,
      DST_Q6,
      DST_Q120
   } dst_type;

   typedef struct packed {
      cond_type               cond;
      logic [STEP_BITS-1:0]   target;
      asel_type               a_sel;
      bsel_type               b_sel;
      post_type               post;
      dst_type                dst;
      logic                   fold;
      logic                   sum;
      logic                   finish;
   } ucode_type;

   typedef struct packed {
      ucode_type word;
      logic      fire;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
   } status_type;

   // microcode program, one control word per step
   function automatic ucode_type ucode(input logic [STEP_BITS-1:0] step);
      ucode_type w;
      w = '{cond: COND_ALWAYS, target: '0, a_sel: A_M, b_sel: B_M, post: POST_Q14,
            dst: DST_NONE, fold: 1'b0, sum: 1'b0, finish: 1'b0};
      case (step)
         3'd0: begin
            // wait for a request, fold the phase on acceptance
            w.cond   = COND_REQ;
            w.target = 3'd1;
            w.fold   = 1'b1;
         end
         3'd1: begin
            w.target = 3'd2;
            w.a_sel  = A_M;
            w.b_sel  = B_M;
            w.post   = POST_Q14;
            w.dst    = DST_X2;
         end
         3'd2: begin
            w.target = 3'd3;
            w.a_sel  = A_X2;
            w.b_sel  = B_M;
            w.post   = POST_Q14;
            w.dst    = DST_X3;
         end
         3'd3: begin
            w.target = 3'd4;
            w.a_sel  = A_X3;
            w.b_sel  = B_X2;
            w.post   = POST_Q14;
            w.dst    = DST_X5;
         end
         3'd4: begin
            w.target = 3'd5;
            w.a_sel  = A_X3R;
            w.b_sel  = B_RECIP6;
            w.post   = POST_SH19;
            w.dst    = DST_Q6;
         end
         3'd5: begin
            w.target = 3'd6;
            w.a_sel  = A_X5R;
            w.b_sel  = B_RECIP120;
            w.post   = POST_SH25;
            w.dst    = DST_Q120;
         end
         3'd6: begin
            w.target = 3'd7;
            w.sum    = 1'b1;
         end
         3'd7: begin
            // duty product, held until the output register is free
            w.cond   = COND_OUT;
            w.target = 3'd0;
            w.a_sel  = A_BIAS;
            w.b_sel  = B_SCALE;
            w.post   = POST_Q16;
            w.finish = 1'b1;
         end
         default: begin
            w.target = 3'd0;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/spdg_req_if.sv
// ----------------------------------------------------------------------------
// spdg_req_if
// request channel carrying the timer tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spdg_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

// File: rtl/spdg_rsp_if.sv
// ----------------------------------------------------------------------------
// spdg_rsp_if
// result channel carrying duty, sine value and cycle start flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spdg_rsp_if #(
   parameter int DUTY_BITS = 6
);
   logic                  valid;
   logic                  ready;
   logic [DUTY_BITS-1:0]  duty;
   logic signed [15:0]    sine_value;
   logic                  cycle_start;

   modport source (output valid, output duty, output sine_value, output cycle_start,
                   input ready);
   modport sink   (input valid, input duty, input sine_value, input cycle_start,
                   output ready);
endinterface

// File: rtl/spdg_csr_if.sv
// ----------------------------------------------------------------------------
// spdg_csr_if
// configuration write channel for the phase step register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spdg_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] phase_step;

   modport source (output valid, output phase_step, input ready);
   modport sink   (input valid, input phase_step, output ready);
endinterface

// File: rtl/spdg_sequencer.sv
// ----------------------------------------------------------------------------
// spdg_sequencer
// step counter and microcode table with conditional jumps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spdg_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  spdg_pkg::status_type  status,
   output spdg_pkg::ctrl_type    ctrl
);

   logic [spdg_pkg::STEP_BITS-1:0] step_ff;
   logic [spdg_pkg::STEP_BITS-1:0] step_in;
   spdg_pkg::ucode_type            word;
   logic                           cond_ok;

   // fetch the control word of the current step
   assign word = spdg_pkg::ucode(step_ff);

   // jump condition
   always_comb begin
      case (word.cond)
         spdg_pkg::COND_ALWAYS: cond_ok = 1'b1;
         spdg_pkg::COND_REQ:    cond_ok = status.req_valid;
         spdg_pkg::COND_OUT:    cond_ok = status.out_free;
         default:               cond_ok = 1'b1;
      endcase
   end

   // take the target when the condition holds, otherwise stay
   assign step_in = cond_ok ? word.target : step_ff;

   assign ctrl.word = word;
   assign ctrl.fire = cond_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: rtl/spdg_datapath.sv
// ----------------------------------------------------------------------------
// spdg_datapath
// phase accumulator, fold, shared multiplier and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spdg_datapath #(
   parameter int DUTY_BITS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  spdg_pkg::ctrl_type  ctrl,
   input  logic                req_tick,
   output logic                out_free,
   spdg_csr_if.sink            csr_chan,
   spdg_rsp_if.source          rsp_chan
);

   localparam int DUTY_LIM = (1 << DUTY_BITS) - 1;
   localparam int DUTY_CAP = (DUTY_LIM < spdg_pkg::DUTY_FULL) ? DUTY_LIM
                                                              : spdg_pkg::DUTY_FULL;

   logic                  fold_go;
   logic                  finish_go;

   logic [14:0]           phase_step_ff, phase_step_in;
   logic [14:0]           phase_ff, phase_in;
   logic                  tick_ff, tick_in;
   logic                  neg_ff, neg_in;
   logic                  cyc_ff, cyc_in;
   logic [14:0]           m_ff, m_in;
   logic [15:0]           x2_ff, x2_in;
   logic [15:0]           x3_ff, x3_in;
   logic [17:0]           x5_ff, x5_in;
   logic [13:0]           q6_ff, q6_in;
   logic [10:0]           q120_ff, q120_in;
   logic signed [15:0]    sine_ff, sine_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0]  rsp_duty_ff, rsp_duty_in;
   logic signed [15:0]    rsp_sine_ff, rsp_sine_in;
   logic                  rsp_cyc_ff, rsp_cyc_in;

   logic [12:0]           mag;
   logic                  mag_neg;
   logic [15:0]           phase_sum;
   logic signed [17:0]    biased;
   logic [17:0]           mul_a;
   logic [18:0]           mul_b;
   logic [36:0]           prod;
   logic [36:0]           post_wide;
   logic [18:0]           mres;
   logic [16:0]           s_mag;
   logic [5:0]            duty_raw;
   logic [5:0]            duty_sat;
   logic [16:0]           duty_ext;

   assign fold_go   = ctrl.word.fold & ctrl.fire;
   assign finish_go = ctrl.word.finish & ctrl.fire;

   // configuration register
   assign csr_chan.ready = 1'b1;
   assign phase_step_in  = csr_chan.valid ? csr_chan.phase_step : phase_step_ff;

   // fold the phase into -pi/2..pi/2 as sign and magnitude
   always_comb begin
      if (phase_ff >= spdg_pkg::THREE_HALF_PI_Q12) begin
         mag     = 13'(spdg_pkg::TWO_PI_Q12 - phase_ff);
         mag_neg = 1'b1;
      end else if (phase_ff > spdg_pkg::PI_Q12) begin
         mag     = 13'(phase_ff - spdg_pkg::PI_Q12);
         mag_neg = 1'b1;
      end else if (phase_ff >= spdg_pkg::HALF_PI_Q12) begin
         mag     = 13'(spdg_pkg::PI_Q12 - phase_ff);
         mag_neg = 1'b0;
      end else begin
         mag     = 13'(phase_ff);
         mag_neg = 1'b0;
      end
   end

   assign tick_in = fold_go ? req_tick : tick_ff;
   assign neg_in  = fold_go ? mag_neg : neg_ff;
   assign cyc_in  = fold_go ? (phase_ff == '0) : cyc_ff;
   assign m_in    = fold_go ? {mag, 2'b00} : m_ff;

   // phase advance for a tick request as the result is issued, back to zero at a full turn
   assign phase_sum = {1'b0, phase_ff} + {1'b0, phase_step_ff};
   always_comb begin
      phase_in = phase_ff;
      if (finish_go && tick_ff) begin
         phase_in = (phase_sum >= {1'b0, spdg_pkg::TWO_PI_Q12}) ? '0 : phase_sum[14:0];
      end
   end

   // bias the sine for the duty product, a biased value at or below zero feeds zero
   assign biased = spdg_pkg::ONE_Q14 + 18'(sine_ff);

   // shared multiplier operand selection
   always_comb begin
      case (ctrl.word.a_sel)
         spdg_pkg::A_M:    mul_a = {3'b000, m_ff};
         spdg_pkg::A_X2:   mul_a = {2'b00, x2_ff};
         spdg_pkg::A_X3:   mul_a = {2'b00, x3_ff};
         spdg_pkg::A_X3R:  mul_a = 18'(x3_ff) + 18'd3;
         spdg_pkg::A_X5R:  mul_a = x5_ff + 18'd60;
         spdg_pkg::A_BIAS: mul_a = (biased > 18'sd0) ? biased : '0;
         default:          mul_a = '0;
      endcase
   end

   always_comb begin
      case (ctrl.word.b_sel)
         spdg_pkg::B_M:        mul_b = {4'b0000, m_ff};
         spdg_pkg::B_X2:       mul_b = {3'b000, x2_ff};
         spdg_pkg::B_RECIP6:   mul_b = spdg_pkg::RECIP_6;
         spdg_pkg::B_RECIP120: mul_b = spdg_pkg::RECIP_120;
         spdg_pkg::B_SCALE:    mul_b = spdg_pkg::DUTY_SCALE;
         default:              mul_b = '0;
      endcase
   end

   assign prod = 37'(mul_a) * 37'(mul_b);

   // scaling of the product, rounded for q14 and q16, truncated for the reciprocals
   always_comb begin
      case (ctrl.word.post)
         spdg_pkg::POST_Q14:  post_wide = (prod + 37'd8192) >> 14;
         spdg_pkg::POST_SH19: post_wide = prod >> 19;
         spdg_pkg::POST_SH25: post_wide = prod >> 25;
         spdg_pkg::POST_Q16:  post_wide = (prod + 37'd32768) >> 16;
         default:             post_wide = '0;
      endcase
   end
   assign mres = post_wide[18:0];

   // product destination
   assign x2_in   = (ctrl.word.dst == spdg_pkg::DST_X2)   ? mres[15:0] : x2_ff;
   assign x3_in   = (ctrl.word.dst == spdg_pkg::DST_X3)   ? mres[15:0] : x3_ff;
   assign x5_in   = (ctrl.word.dst == spdg_pkg::DST_X5)   ? mres[17:0] : x5_ff;
   assign q6_in   = (ctrl.word.dst == spdg_pkg::DST_Q6)   ? mres[13:0] : q6_ff;
   assign q120_in = (ctrl.word.dst == spdg_pkg::DST_Q120) ? mres[10:0] : q120_ff;

   // polynomial sum and sign restore
   assign s_mag   = {2'b00, m_ff} - {3'b000, q6_ff} + {6'b000000, q120_ff};
   assign sine_in = ctrl.word.sum ? (neg_ff ? -$signed(s_mag[15:0]) : $signed(s_mag[15:0]))
                                  : sine_ff;

   // duty saturation and width fit
   assign duty_raw = mres[5:0];
   assign duty_sat = (duty_raw > 6'(DUTY_CAP)) ? 6'(DUTY_CAP) : duty_raw;
   assign duty_ext = {11'b0, duty_sat};

   // output register
   assign out_free = ~rsp_valid_ff | rsp_chan.ready;
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_duty_in  = rsp_duty_ff;
      rsp_sine_in  = rsp_sine_ff;
      rsp_cyc_in   = rsp_cyc_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_duty_in  = duty_ext[DUTY_BITS-1:0];
         rsp_sine_in  = sine_ff;
         rsp_cyc_in   = cyc_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.duty        = rsp_duty_ff;
   assign rsp_chan.sine_value  = rsp_sine_ff;
   assign rsp_chan.cycle_start = rsp_cyc_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= spdg_pkg::STEP_RESET;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_step_ff <= phase_step_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      tick_ff     <= tick_in;
      neg_ff      <= neg_in;
      cyc_ff      <= cyc_in;
      m_ff        <= m_in;
      x2_ff       <= x2_in;
      x3_ff       <= x3_in;
      x5_ff       <= x5_in;
      q6_ff       <= q6_in;
      q120_ff     <= q120_in;
      sine_ff     <= sine_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_sine_ff <= rsp_sine_in;
      rsp_cyc_ff  <= rsp_cyc_in;
   end

endmodule

// File: rtl/sine_pwm_duty_generator_unit.sv
// A request is accepted at the first step and its result is registered at the last
// step of the eight-step microcode program, which runs all products through one
// shared 18x19 multiplier; no new request is taken until the program has finished.
// A result waiting in the output register stalls only the final step.
// Reset (synchronous): step counter to zero, phase to zero, phase step to 306.
// ----------------------------------------------------------------------------
// sine_pwm_duty_generator_unit
// microcoded taylor sine duty generator for sine-modulated pwm
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sine_pwm_duty_generator_unit_defines.svh"

module sine_pwm_duty_generator_unit #(
   parameter int DUTY_BITS = 6
) (
   input  logic         clock,
   input  logic         reset,
   spdg_req_if.sink     req_chan,
   spdg_rsp_if.source   rsp_chan,
   spdg_csr_if.sink     csr_chan
);

   localparam int DUTY_LIM  = (1 << DUTY_BITS) - 1;
   localparam int ZERO_DUTY = (DUTY_LIM < 16) ? DUTY_LIM : 16;

   spdg_pkg::ctrl_type    seq_ctrl;
   spdg_pkg::status_type  seq_status;
   logic                  out_free;

   // a request is taken only while the program waits at its first step
   assign req_chan.ready       = (seq_ctrl.word.cond == spdg_pkg::COND_REQ);
   assign seq_status.req_valid = req_chan.valid;
   assign seq_status.out_free  = out_free;

   spdg_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (seq_status),
      .ctrl   (seq_ctrl)
   );

   spdg_datapath #(
      .DUTY_BITS (DUTY_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (seq_ctrl),
      .req_tick (req_chan.tick),
      .out_free (out_free),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

   // checks
   `SPDG_ASSERT_NEXT(a_one_in_flight, clock, reset,
      req_chan.valid && req_chan.ready, !req_chan.ready,
      "request taken while one is in progress")
   `SPDG_ASSERT_NOW(a_zero_phase, clock, reset,
      rsp_chan.valid && rsp_chan.cycle_start,
      rsp_chan.sine_value == 16'sd0 && rsp_chan.duty == DUTY_BITS'(ZERO_DUTY),
      "phase zero result not mid scale")
   `SPDG_ASSERT_NOW(a_no_overwrite, clock, reset,
      seq_ctrl.fire && seq_ctrl.word.finish, !rsp_chan.valid || rsp_chan.ready,
      "output register overwritten")

endmodule

// File: sim/sine_pwm_duty_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// sine pwm duty generator testbench
// sends tick requests and phase step writes under varied back-pressure, and
// checks every duty, sine and cycle start result against the typed values of
// the directed table or a fixed point taylor sine predictor kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_pwm_duty_generator_unit_tb;

   localparam int DUTY_BITS     = 6;

   // angle constants, q3.12 radians
   localparam int ANGLE_TURN    = 25736;
   localparam int ANGLE_3HALF   = 19302;
   localparam int ANGLE_HALF    = 6434;
   localparam int ANGLE_PI      = 12868;

   localparam int STEP_DEFAULT  = 306;
   localparam int STEP_MAX      = 32767;
   localparam int STEP_TURN_MAX = 25735;

   localparam int DUTY_CAP      = ((1 << DUTY_BITS) - 1 < 32) ? (1 << DUTY_BITS) - 1 : 32;
   localparam int DUTY_MID      = 16;
   localparam int SINE_PEAK     = 16458;

   localparam int IDLE_LIMIT      = 1000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int MAX_REPORTS     = 10;
   localparam int RAND_PHASES     = 12;
   localparam int ITEMS_PER_PHASE = 44;
   localparam int HOLD_PHASE      = 8;
   localparam int HOLD_CYCLES     = 200;

   typedef struct packed {
      logic [DUTY_BITS-1:0] duty;
      logic signed [15:0]   sine_value;
      logic                 cycle_start;
   } duty_word_type;

   typedef struct {
      bit write_step;
      int step;
      bit tick;
      bit typed;
      int duty;
      int sine;
      bit start;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;

   // write_step, step, tick, typed, duty, sine, start
   stim_row_type dir_rows [DIRECTED_ROWS] = '{
      // phase zero straight after reset, idle call then a tick
      '{0, 0, 0, 1, DUTY_MID, 0, 1},
      '{0, 0, 1, 1, DUTY_MID, 0, 1},
      '{0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 1, 0, 0, 0, 0},
      // zero step holds the phase
      '{1, 0, 1, 0, 0, 0, 0},
      '{0, 0, 1, 0, 0, 0, 0},
      // land exactly on pi/2, positive peak
      '{1, 5822, 1, 0, 0, 0, 0},
      '{0, 0, 0, 1, DUTY_CAP, SINE_PEAK, 0},
      // on to 3*pi/2, negative peak clamps the duty to zero
      '{1, ANGLE_PI, 1, 1, DUTY_CAP, SINE_PEAK, 0},
      '{0, 0, 0, 1, 0, -SINE_PEAK, 0},
      // one below a full turn, then the wrap drops the remainder
      '{1, 6433, 1, 1, 0, -SINE_PEAK, 0},
      '{0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 1, 0, 0, 0, 0},
      '{0, 0, 0, 1, DUTY_MID, 0, 1},
      // all-ones step overshoots a turn at once
      '{1, STEP_MAX, 1, 1, DUTY_MID, 0, 1},
      '{0, 0, 0, 1, DUTY_MID, 0, 1},
      // smallest step
      '{1, 1, 1, 1, DUTY_MID, 0, 1},
      '{0, 0, 1, 0, 0, 0, 0},
      // just past pi, then a sum beyond the turn
      '{1, ANGLE_PI, 1, 0, 0, 0, 0},
      '{0, 0, 1, 0, 0, 0, 0},
      '{0, 0, 0, 1, DUTY_MID, 0, 1},
      // largest step that stays inside one turn
      '{1, STEP_TURN_MAX, 1, 1, DUTY_MID, 0, 1},
      '{0, 0, 1, 0, 0, 0, 0},
      '{1, STEP_DEFAULT, 0, 1, DUTY_MID, 0, 1}
   };

   logic clock;
   logic reset;

   spdg_req_if                          req_bus ();
   spdg_rsp_if #(.DUTY_BITS(DUTY_BITS)) rsp_bus ();
   spdg_csr_if                          csr_bus ();

   sine_pwm_duty_generator_unit #(
      .DUTY_BITS (DUTY_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // bench copy of the block state
   int phase_now;
   int step_now;

   duty_word_type duty_due_q [$];
   int fail_count      = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int hold_order      = 0;

   // taylor sine of a q3.12 angle and the duty it gives
   function automatic duty_word_type predict_duty(input int ang);
      int            x;
      bit            neg;
      longint        m;
      longint        x2;
      longint        x3;
      longint        x5;
      longint        s;
      longint        biased;
      longint        d;
      duty_word_type w;
      x = ang;
      // fold into -pi/2..pi/2
      if (x >= ANGLE_3HALF) begin
         x = x - ANGLE_TURN;
      end else if (x >= ANGLE_HALF) begin
         x = ANGLE_PI - x;
      end
      neg = (x < 0);
      m   = longint'(neg ? -x : x);
      m   = m * 4;
      x2  = (m * m + 8192) >> 14;
      x3  = (x2 * m + 8192) >> 14;
      x5  = (x3 * x2 + 8192) >> 14;
      s   = m - (x3 + 3) / 6 + (x5 + 60) / 120;
      if (neg) begin
         s = -s;
      end
      biased = 16384 + s;
      d = 0;
      if (biased > 0) begin
         d = (biased * 63 + 32768) >> 16;
      end
      if (d > DUTY_CAP) begin
         d = DUTY_CAP;
      end
      w.duty        = d[DUTY_BITS-1:0];
      w.sine_value  = s[15:0];
      w.cycle_start = (ang == 0);
      return w;
   endfunction

   // one tick request, expectation logged on acceptance
   task automatic send_tick(input bit tick, input bit typed, input duty_word_type typed_w);
      int nxt;
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.tick  <= tick;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      duty_due_q.push_back(typed ? typed_w : predict_duty(phase_now));
      if (tick) begin
         nxt       = phase_now + step_now;
         phase_now = (nxt >= ANGLE_TURN) ? 0 : nxt;
      end
   endtask

   // stop sending, let every result come back and the block settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (duty_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_phase_step(input int value);
      csr_bus.valid      <= 1'b1;
      csr_bus.phase_step <= value[14:0];
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      step_now = value & 32'h7FFF;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: back-pressure and checking
   initial begin
      duty_word_type want;
      int            hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (duty_due_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("unexpected result: duty %0d sine %0d start %0b",
                           rsp_bus.duty, rsp_bus.sine_value, rsp_bus.cycle_start);
               end
            end else begin
               want = duty_due_q.pop_front();
               if (rsp_bus.duty !== want.duty || rsp_bus.sine_value !== want.sine_value ||
                   rsp_bus.cycle_start !== want.cycle_start) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("mismatch: expected duty %0d sine %0d start %0b, got %0d %0d %0b",
                              want.duty, want.sine_value, want.cycle_start,
                              rsp_bus.duty, rsp_bus.sine_value, rsp_bus.cycle_start);
                  end
               end
            end
         end
         // long hold-off, counted here
         if (hold_left == 0 && hold_order != 0) begin
            hold_left  = hold_order;
            hold_order = 0;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // watchdog on cycles with no request, result or write accepted
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("** sine_pwm_duty_generator_unit: FAILED **");
      $finish;
   end

   // stimulus
   initial begin
      duty_word_type typed_w;
      int            nstep;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.tick       = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.phase_step = '0;
      phase_now          = 0;
      step_now           = STEP_DEFAULT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].write_step) begin
            wait_idle();
            write_phase_step(dir_rows[i].step);
         end
         typed_w.duty        = DUTY_BITS'(dir_rows[i].duty);
         typed_w.sine_value  = 16'(dir_rows[i].sine);
         typed_w.cycle_start = dir_rows[i].start;
         send_tick(dir_rows[i].tick, dir_rows[i].typed, typed_w);
      end

      // random phases, each with a step of its own and one of four idling mixes
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_idle();
         case (ph)
            1: nstep = 1;
            2: nstep = STEP_TURN_MAX;
            3: nstep = STEP_MAX;
            4: nstep = 0;
            5: nstep = ANGLE_PI;
            default: begin
               if ($urandom_range(0, 4) == 0) begin
                  nstep = $urandom_range(0, STEP_MAX);
               end else begin
                  nstep = $urandom_range(50, 3000);
               end
            end
         endcase
         write_phase_step(nstep);
         case (ph % 4)
            0: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
            end
            1: begin
               sender_idle_pct = 48;
               rsp_stall_pct   = 0;
            end
            2: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 48;
            end
            default: begin
               sender_idle_pct = 13;
               rsp_stall_pct   = 13;
            end
         endcase
         // receiver holds off while requests keep coming, filling the block
         if (ph == HOLD_PHASE) begin
            hold_order = HOLD_CYCLES;
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            send_tick($urandom_range(0, 99) >= 15, 1'b0, '0);
         end
      end

      wait_idle();
      if (fail_count == 0 && duty_due_q.size() == 0) begin
         $display("** sine_pwm_duty_generator_unit: PASSED **");
      end else begin
         $display("** sine_pwm_duty_generator_unit: FAILED **");
      end
      $finish;
   end

endmodule
